### rtl/xobe_pkg.sv
// ----------------------------------------------------------------------------
// xobe_pkg : shared types and constants of the x86 operand byte encoder
// Byte codes for ModRM/SIB/REX fields, operand kinds and the frame of
// encoded bytes handed from the encoder to the output serializer.
// ----------------------------------------------------------------------------
package xobe_pkg;

	// Longest instruction: REX, two opcodes, ModRM, SIB, disp32
	localparam int unsigned MaxBytes = 9;
	localparam int unsigned CountW   = $clog2(MaxBytes + 1);

	// Operand kind codes (rm_kind)
	localparam logic [1:0] KIND_REG = 2'd0;
	localparam logic [1:0] KIND_MEM = 2'd1;

	// Action codes
	localparam logic ACT_RM  = 1'b0;
	localparam logic ACT_EXT = 1'b1;

	// ModRM / SIB field codes
	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;
	localparam logic [2:0] RM_SIB     = 3'b100;
	localparam logic [2:0] RM_DISP    = 3'b101;
	localparam logic [3:0] REX_HIGH   = 4'b0100;
	localparam logic [3:0] REG_RSP    = 4'd4;

	// Displacement sizes in bytes
	localparam logic [2:0] DSZ_0 = 3'd0;
	localparam logic [2:0] DSZ_1 = 3'd1;
	localparam logic [2:0] DSZ_4 = 3'd4;

	// One decoded instruction operand
	typedef struct packed {
		logic        action;
		logic [7:0]  opcode_first;
		logic [7:0]  opcode_second;
		logic        two_byte_opcode;
		logic [3:0]  reg_index;
		logic        reg_is_64;
		logic [1:0]  rm_kind;
		logic [3:0]  rm_reg_a;
		logic [3:0]  rm_reg_b;
		logic [1:0]  mem_reg_count;
		logic [1:0]  mem_scale;
		logic [31:0] displacement;
	} xobe_item_t;

	// Encoded bytes, byte 0 goes out first
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [CountW-1:0]        count;
	} xobe_frame_t;

endpackage

### rtl/xobe_encoder.sv
// ----------------------------------------------------------------------------
// xobe_encoder : combinational operand encoder
// Works out REX, ModRM, SIB and displacement size for one item and lays the
// instruction bytes out in order.
// ----------------------------------------------------------------------------
module xobe_encoder (
	input  xobe_pkg::xobe_item_t  item,
	output xobe_pkg::xobe_frame_t frame
);
	import xobe_pkg::*;

	logic       r_bit, x_bit, b_bit, has_rex, sib;
	logic [1:0] mod;
	logic [2:0] rm;
	logic [2:0] dsize;
	logic [7:0] modrm, sib_val, rex_byte;
	logic [1:0] cnt;
	logic [3:0] idx, base, t;
	logic       need, dz, d8;
	logic [CountW-1:0] p_op, p_modrm, p_disp;

	assign dz = (item.displacement == 32'd0);
	assign d8 = (item.displacement[31:7] == '0) || (item.displacement[31:7] == '1);

	always_comb begin
		r_bit    = 1'b0;
		x_bit    = 1'b0;
		b_bit    = 1'b0;
		sib      = 1'b0;
		mod      = MOD_NODISP;
		rm       = 3'd0;
		dsize    = DSZ_0;
		sib_val  = 8'd0;
		cnt      = (item.mem_reg_count == 2'd3) ? 2'd2 : item.mem_reg_count;
		idx      = 4'd0;
		base     = 4'd0;
		t        = 4'd0;
		need     = 1'b0;
		if (item.action == ACT_EXT) begin
			b_bit = item.rm_reg_a[3];
			mod   = MOD_REG;
			rm    = item.rm_reg_a[2:0];
		end else begin
			r_bit = item.reg_index[3];
			if (item.rm_kind == KIND_REG) begin
				mod   = MOD_REG;
				rm    = item.rm_reg_a[2:0];
				b_bit = item.rm_reg_a[3];
			end else if (item.rm_kind != KIND_MEM) begin
				mod   = MOD_NODISP;
				rm    = RM_DISP;
				dsize = DSZ_4;
			end else begin
				if (dz) begin
					mod = MOD_NODISP; dsize = DSZ_0;
				end else if (d8) begin
					mod = MOD_DISP8; dsize = DSZ_1;
				end else begin
					mod = MOD_DISP32; dsize = DSZ_4;
				end
				sib = (cnt != 2'd1) || (item.rm_reg_a[2:0] == RM_SIB) ||
					(item.mem_scale != 2'd0);
				if (!sib) begin
					rm    = item.rm_reg_a[2:0];
					b_bit = item.rm_reg_a[3];
					if (rm == RM_DISP && mod == MOD_NODISP) begin
						mod = MOD_DISP8; dsize = DSZ_1;
					end
				end else begin
					idx  = (cnt > 2'd0) ? item.rm_reg_a : {1'b0, RM_SIB};
					base = (cnt > 2'd1) ? item.rm_reg_b : {1'b0, RM_DISP};
					need = (cnt > 2'd1) && (base[2:0] == RM_DISP);
					// rbp/r13 base with scale 1: move it to the index
					if (need && base[2:0] != idx[2:0] && base[2:0] != RM_SIB &&
						item.mem_scale == 2'd0) begin
						t    = idx;
						idx  = base;
						base = t;
						need = 1'b0;
					end
					// rsp cannot be an index
					if (cnt > 2'd0 && idx[2:0] == RM_SIB) begin
						if (cnt == 2'd1) begin
							if (idx == REG_RSP) base = REG_RSP;
						end else if (idx == REG_RSP) begin
							t    = idx;
							idx  = base;
							base = t;
						end
						if (cnt > 2'd1 && base[2:0] == RM_DISP) need = 1'b1;
					end
					if (need) begin
						if (mod == MOD_NODISP) begin
							mod = MOD_DISP8; dsize = DSZ_1;
						end
					end else if (base[2:0] == RM_DISP) begin
						mod = MOD_NODISP; dsize = DSZ_4;
					end
					rm      = RM_SIB;
					x_bit   = idx[3];
					b_bit   = base[3];
					sib_val = {item.mem_scale, idx[2:0], base[2:0]};
				end
			end
		end
	end

	assign modrm    = {mod, item.reg_index[2:0], rm};
	assign has_rex  = item.reg_is_64 | r_bit | x_bit | b_bit;
	assign rex_byte = {REX_HIGH, item.reg_is_64, r_bit, x_bit, b_bit};

	// Byte positions within the instruction
	assign p_op    = CountW'(has_rex);
	assign p_modrm = p_op + CountW'(1) + CountW'(item.two_byte_opcode);
	assign p_disp  = p_modrm + CountW'(1) + CountW'(sib);

	always_comb begin
		frame.count = p_disp + CountW'(dsize);
		for (int i = 0; i < MaxBytes; i++) begin
			frame.bytes[i] = 8'd0;
			if (has_rex && i == 0)
				frame.bytes[i] = rex_byte;
			if (CountW'(i) == p_op)
				frame.bytes[i] = item.opcode_first;
			if (item.two_byte_opcode && CountW'(i) == p_op + CountW'(1))
				frame.bytes[i] = item.opcode_second;
			if (CountW'(i) == p_modrm)
				frame.bytes[i] = modrm;
			if (sib && CountW'(i) == p_modrm + CountW'(1))
				frame.bytes[i] = sib_val;
			for (int j = 0; j < 4; j++) begin
				if (CountW'(j) < CountW'(dsize) && CountW'(i) == p_disp + CountW'(j))
					frame.bytes[i] = item.displacement[8*j +: 8];
			end
		end
	end

endmodule

### rtl/xobe_serializer.sv
// ----------------------------------------------------------------------------
// xobe_serializer : result byte shifter
// Holds one encoded instruction and sends its bytes one byte at a time.
// ----------------------------------------------------------------------------
module xobe_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	output logic                  load_ready,
	input  xobe_pkg::xobe_frame_t frame,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  out_last,
	output logic [xobe_pkg::CountW-1:0] remaining
);
	import xobe_pkg::*;

	logic [MaxBytes-1:0][7:0] bytes_q;
	logic [CountW-1:0]        rem_q;
	logic                     take;

	assign out_valid  = (rem_q != '0);
	assign out_byte   = bytes_q[0];
	assign out_last   = (rem_q == CountW'(1));
	assign take       = out_valid && out_ready;
	assign load_ready = !out_valid || (take && out_last);
	assign remaining  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load_valid && load_ready) begin
			rem_q <= frame.count;
		end else if (take) begin
			rem_q <= rem_q - CountW'(1);
		end
	end

	// Advance the byte window on each take
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			bytes_q <= frame.bytes;
		end else if (take) begin
			bytes_q <= {8'd0, bytes_q[MaxBytes-1:1]};
		end
	end

endmodule

### rtl/x86_operand_byte_encoder.sv
// ----------------------------------------------------------------------------
// x86_operand_byte_encoder : x86-64 REX/opcode/ModRM/SIB/displacement encoder
// Turns one operand description into the byte sequence of the instruction.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents
// s_axis    in         one instruction: opcodes, register and r/m operand
// m_axis    out        one instruction byte, tlast on the final byte
//
// An accepted word lands in the input register, the combinational encoder
// lays out all bytes and they load into the output shifter, which sends one
// byte per cycle while m_tready is high. An instruction is 2 to 9 bytes (REX,
// one or two opcodes, ModRM, optional SIB, disp 0/1/4); the shifter's one
// byte per cycle sets the sustained rate. The next word is taken while the
// current one is still being sent, so back-to-back instructions leave with
// no gap. A stalled m_tready holds the current byte; reset empties both
// the input register and the shifter.
//
module x86_operand_byte_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] opcode_first, [15:8] opcode_second, [16] two_byte_opcode,
	// [20:17] reg_index, [21] reg_is_64, [25:22] rm_reg_a, [29:26] rm_reg_b,
	// [31:30] mem_reg_count, [33:32] mem_scale, [65:34] displacement, [71:66] zero
	input  logic [71:0] s_tdata,
	// [0] action, [2:1] rm_kind
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);
	import xobe_pkg::*;

	xobe_item_t        item_s1;
	logic              valid_s1;
	xobe_frame_t       frame;
	logic              load_ready;
	logic [CountW-1:0] remaining;

	// Input register: take a word when empty or when it moves on this cycle
	assign s_tready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Unpack the word; payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action          <= s_tuser[0];
			item_s1.rm_kind         <= s_tuser[2:1];
			item_s1.opcode_first    <= s_tdata[7:0];
			item_s1.opcode_second   <= s_tdata[15:8];
			item_s1.two_byte_opcode <= s_tdata[16];
			item_s1.reg_index       <= s_tdata[20:17];
			item_s1.reg_is_64       <= s_tdata[21];
			item_s1.rm_reg_a        <= s_tdata[25:22];
			item_s1.rm_reg_b        <= s_tdata[29:26];
			item_s1.mem_reg_count   <= s_tdata[31:30];
			item_s1.mem_scale       <= s_tdata[33:32];
			item_s1.displacement    <= s_tdata[65:34];
		end
	end

	// Encode in one pass
	xobe_encoder u_encoder (
		.item  (item_s1),
		.frame (frame)
	);

	// Send the bytes out one per cycle while m_tready is high
	xobe_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.frame      (frame),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.remaining  (remaining)
	);

	// The shifter never holds more bytes than the longest instruction
	assert property (@(posedge clk) disable iff (!arst_n)
		remaining <= CountW'(MaxBytes))
		else $error("byte count out of range");

	// A waiting instruction is held until the shifter takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_ready |=> valid_s1 && $stable(item_s1))
		else $error("pending instruction lost");

	// A byte that is not the last is always followed by another
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("instruction cut short");

	// A waiting instruction follows the last byte without a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && valid_s1 |=> m_tvalid)
		else $error("gap between instructions");

endmodule

### test/xobe_byte_checker.sv
// ----------------------------------------------------------------------------
// xobe_byte_checker : byte-stream checker for the x86 operand byte encoder
// Watches both channels, encodes every accepted operand word on its own and
// compares each sent byte and its tlast against the oldest byte still due.
// ----------------------------------------------------------------------------
module xobe_byte_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          bytes_due
);
	import xobe_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	enc_byte_t due_bytes[$];
	int        bytes_seen;

	initial begin
		errors     = 0;
		bytes_due  = 0;
		bytes_seen = 0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at output byte %0d: %s", bytes_seen, what);
		errors++;
	endtask

	// Lay out the bytes of one instruction and queue them in send order.
	function automatic void queue_instruction_bytes(input xobe_item_t op);
		logic               rex_r, rex_x, rex_b;
		logic [1:0]         mod;
		logic [2:0]         rm;
		logic [7:0]         modrm, sib_val;
		logic               use_sib, need_disp;
		logic [1:0]         count;
		logic [3:0]         idx, base, tmp;
		logic signed [31:0] disp;
		int                 dsize;
		logic [7:0]         seq[$];
		enc_byte_t          entry;
		rex_r     = 1'b0;
		rex_x     = 1'b0;
		rex_b     = 1'b0;
		mod       = MOD_NODISP;
		rm        = 3'd0;
		use_sib   = 1'b0;
		sib_val   = 8'd0;
		dsize     = 0;
		disp      = signed'(op.displacement);
		if (op.action == ACT_EXT) begin
			// extension lives in reg, register in r/m, memory fields ignored
			rex_b = op.rm_reg_a[3];
			modrm = {MOD_REG, op.reg_index[2:0], op.rm_reg_a[2:0]};
		end else begin
			rex_r = op.reg_index[3];
			if (op.rm_kind == KIND_REG) begin
				mod   = MOD_REG;
				rm    = op.rm_reg_a[2:0];
				rex_b = op.rm_reg_a[3];
			end else if (op.rm_kind != KIND_MEM) begin
				// RIP-relative: mod 00, r/m 101, disp32
				mod   = MOD_NODISP;
				rm    = RM_DISP;
				dsize = 4;
			end else begin
				count = (op.mem_reg_count > 2'd2) ? 2'd2 : op.mem_reg_count;
				if (disp == 0) begin
					mod   = MOD_NODISP;
					dsize = 0;
				end else if (disp >= -128 && disp <= 127) begin
					mod   = MOD_DISP8;
					dsize = 1;
				end else begin
					mod   = MOD_DISP32;
					dsize = 4;
				end
				use_sib = (count != 2'd1) || (op.rm_reg_a[2:0] == RM_SIB) ||
					(op.mem_scale != 2'd0);
				if (!use_sib) begin
					rm    = op.rm_reg_a[2:0];
					rex_b = op.rm_reg_a[3];
					// rbp/r13 with mod 00 would mean disp32, force disp8 of 0
					if (rm == RM_DISP && mod == MOD_NODISP) begin
						mod   = MOD_DISP8;
						dsize = 1;
					end
				end else begin
					idx       = (count > 2'd0) ? op.rm_reg_a : REG_RSP;
					base      = (count > 2'd1) ? op.rm_reg_b : {1'b0, RM_DISP};
					need_disp = (count > 2'd1) && (base[2:0] == RM_DISP);
					// move an rbp/r13 base into the index when the scale allows
					if (need_disp && base[2:0] != idx[2:0] && base[2:0] != RM_SIB &&
						op.mem_scale == 2'd0) begin
						tmp       = idx;
						idx       = base;
						base      = tmp;
						need_disp = 1'b0;
					end
					// rsp cannot be an index
					if (count > 2'd0 && idx[2:0] == RM_SIB) begin
						if (count == 2'd1) begin
							if (idx == REG_RSP)
								base = REG_RSP;
						end else if (idx == REG_RSP) begin
							tmp  = idx;
							idx  = base;
							base = tmp;
						end
						if (count > 2'd1 && base[2:0] == RM_DISP)
							need_disp = 1'b1;
					end
					if (need_disp) begin
						if (mod == MOD_NODISP) begin
							mod   = MOD_DISP8;
							dsize = 1;
						end
					end else if (base[2:0] == RM_DISP) begin
						mod   = MOD_NODISP;
						dsize = 4;
					end
					rm      = RM_SIB;
					rex_x   = idx[3];
					rex_b   = base[3];
					sib_val = {op.mem_scale, idx[2:0], base[2:0]};
				end
			end
			modrm = {mod, op.reg_index[2:0], rm};
		end
		if (op.reg_is_64 | rex_r | rex_x | rex_b)
			seq.insert(seq.size(), {REX_HIGH, op.reg_is_64, rex_r, rex_x, rex_b});
		seq.insert(seq.size(), op.opcode_first);
		if (op.two_byte_opcode)
			seq.insert(seq.size(), op.opcode_second);
		seq.insert(seq.size(), modrm);
		if (use_sib)
			seq.insert(seq.size(), sib_val);
		for (int i = 0; i < dsize; i++)
			seq.insert(seq.size(), op.displacement[8*i +: 8]);
		foreach (seq[i]) begin
			entry.data = seq[i];
			entry.last = (i == seq.size() - 1);
			due_bytes.insert(due_bytes.size(), entry);
		end
	endfunction

	always @(posedge clk) begin
		xobe_item_t op;
		enc_byte_t  want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				op                 = '0;
				op.action          = s_tuser[0];
				op.rm_kind         = s_tuser[2:1];
				op.opcode_first    = s_tdata[7:0];
				op.opcode_second   = s_tdata[15:8];
				op.two_byte_opcode = s_tdata[16];
				op.reg_index       = s_tdata[20:17];
				op.reg_is_64       = s_tdata[21];
				op.rm_reg_a        = s_tdata[25:22];
				op.rm_reg_b        = s_tdata[29:26];
				op.mem_reg_count   = s_tdata[31:30];
				op.mem_scale       = s_tdata[33:32];
				op.displacement    = s_tdata[65:34];
				queue_instruction_bytes(op);
			end
			if (m_tvalid && m_tready) begin
				if (due_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", m_tdata));
				end else begin
					want = due_bytes.pop_front();
					if (m_tdata !== want.data)
						report_mismatch($sformatf("byte %02h, expected %02h",
							m_tdata, want.data));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("tlast %b, expected %b",
							m_tlast, want.last));
				end
				bytes_seen++;
			end
			bytes_due = due_bytes.size();
		end
	end

endmodule

### test/tb_x86_operand_byte_encoder.sv
// ----------------------------------------------------------------------------
// tb_x86_operand_byte_encoder : stimulus and verdict for the operand encoder
// Sends directed operand words (register, memory, RIP-relative, rsp/rbp
// corner cases, displacement size limits), then random ones under random
// gaps on both sides, a long output stall and a gap-free stretch. The
// byte checker beside the encoder predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_x86_operand_byte_encoder;
	import xobe_pkg::*;

	// rm_kind codes the package leaves unnamed: both select RIP-relative
	localparam logic [1:0] KIND_RIP     = 2'd2;
	localparam logic [1:0] KIND_RIP_ALT = 2'd3;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 90;
	localparam int GAP_PERCENT  = 14;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	int errors;
	int bytes_due;
	int cycles;

	// gap enables for each side and the request for a long output stall
	bit tx_gaps;
	bit rx_gaps;
	bit hold_output;

	x86_operand_byte_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	xobe_byte_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.errors    (errors),
		.bytes_due (bytes_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Output side: random stalls, or one long hold on request while the
	// sender keeps offering words so the encoder fills and drops s_tready.
	always begin
		@(posedge clk);
		if (hold_output) begin
			hold_output = 1'b0;
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
		end else begin
			m_tready <= rx_gaps ? ($urandom_range(99) >= GAP_PERCENT) : 1'b1;
		end
	end

	function automatic xobe_item_t make_operand(
		input logic act, input logic [1:0] kind, input logic [3:0] reg_idx,
		input logic w, input logic [3:0] ra, input logic [3:0] rb,
		input logic [1:0] count, input logic [1:0] scale, input logic [31:0] disp
	);
		xobe_item_t op;
		op.action          = act;
		op.opcode_first    = 8'($urandom);
		op.opcode_second   = 8'($urandom);
		op.two_byte_opcode = 1'($urandom);
		op.reg_index       = reg_idx;
		op.reg_is_64       = w;
		op.rm_kind         = kind;
		op.rm_reg_a        = ra;
		op.rm_reg_b        = rb;
		op.mem_reg_count   = count;
		op.mem_scale       = scale;
		op.displacement    = disp;
		return op;
	endfunction

	// Favor rsp, rbp, r12 and r13, where the addressing rules bend.
	function automatic logic [3:0] pick_register();
		logic [3:0] odd_regs[4];
		odd_regs = '{4'd4, 4'd5, 4'd12, 4'd13};
		if ($urandom_range(99) < 45)
			return odd_regs[$urandom_range(3)];
		return 4'($urandom_range(15));
	endfunction

	// Spread displacements over the none / disp8 / disp32 choice.
	function automatic logic [31:0] pick_displacement();
		logic [7:0]  short_disp;
		logic [31:0] edges[6];
		edges = '{32'd127, 32'd128, 32'hFFFF_FF80, 32'hFFFF_FF7F,
			32'h7FFF_FFFF, 32'h8000_0000};
		short_disp = 8'($urandom);
		case ($urandom_range(5))
			0:       return 32'd0;
			1, 2:    return {{24{short_disp[7]}}, short_disp};
			3:       return edges[$urandom_range(5)];
			default: return $urandom;
		endcase
	endfunction

	function automatic xobe_item_t random_operand();
		xobe_item_t op;
		int         pick;
		op = make_operand(($urandom_range(99) < 15) ? ACT_EXT : ACT_RM, KIND_MEM,
			4'($urandom_range(15)), 1'($urandom), pick_register(), pick_register(),
			2'($urandom_range(3)),
			($urandom_range(99) < 40) ? 2'd0 : 2'($urandom_range(3)),
			pick_displacement());
		pick = $urandom_range(99);
		if (pick < 18)
			op.rm_kind = KIND_REG;
		else if (pick < 88)
			op.rm_kind = KIND_MEM;
		else if (pick < 96)
			op.rm_kind = KIND_RIP;
		else
			op.rm_kind = KIND_RIP_ALT;
		return op;
	endfunction

	// Offer one word and hold it until accepted; valid stays up afterwards
	// unless the next call opens a gap.
	task automatic offer_operand(input xobe_item_t op);
		while (tx_gaps && $urandom_range(99) < GAP_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {op.rm_kind, op.action};
		s_tdata  <= {6'd0, op.displacement, op.mem_scale, op.mem_reg_count,
			op.rm_reg_b, op.rm_reg_a, op.reg_is_64, op.reg_index,
			op.two_byte_opcode, op.opcode_second, op.opcode_first};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		xobe_item_t op;
		tx_gaps     = 1'b1;
		rx_gaps     = 1'b1;
		hold_output = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		m_tready    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register form, all-zero and all-one extremes
		op = make_operand(ACT_RM, KIND_REG, 4'd0, 1'b0, 4'd0, 4'd0, 2'd0, 2'd0, 32'd0);
		op.opcode_first    = 8'h00;
		op.opcode_second   = 8'h00;
		op.two_byte_opcode = 1'b0;
		offer_operand(op);
		op = make_operand(ACT_RM, KIND_REG, 4'd15, 1'b1, 4'd15, 4'd15, 2'd3, 2'd3,
			32'hFFFF_FFFF);
		op.opcode_first    = 8'hFF;
		op.opcode_second   = 8'hFF;
		op.two_byte_opcode = 1'b1;
		offer_operand(op);
		// extension form: extension masked to 3 bits, memory fields ignored
		offer_operand(make_operand(ACT_EXT, KIND_MEM, 4'd15, 1'b0, 4'd13, 4'd5,
			2'd2, 2'd3, 32'h8000_0000));
		offer_operand(make_operand(ACT_EXT, KIND_RIP, 4'd0, 1'b1, 4'd7, 4'd4,
			2'd1, 2'd0, 32'd5));
		// RIP-relative, both kind codes
		offer_operand(make_operand(ACT_RM, KIND_RIP, 4'd9, 1'b0, 4'd3, 4'd2,
			2'd1, 2'd0, 32'h7FFF_FFFF));
		offer_operand(make_operand(ACT_RM, KIND_RIP_ALT, 4'd2, 1'b1, 4'd0, 4'd0,
			2'd0, 2'd0, 32'h8000_0000));
		// one register: plain, rbp zero displacement, disp8 and disp32 edges
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd1, 1'b0, 4'd0, 4'd0,
			2'd1, 2'd0, 32'd0));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd2, 1'b0, 4'd5, 4'd0,
			2'd1, 2'd0, 32'd0));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd10, 1'b1, 4'd13, 4'd0,
			2'd1, 2'd0, 32'd127));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd3, 1'b0, 4'd4, 4'd0,
			2'd1, 2'd0, 32'hFFFF_FF80));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd4, 1'b0, 4'd12, 4'd0,
			2'd1, 2'd0, 32'd128));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd5, 1'b1, 4'd3, 4'd0,
			2'd1, 2'd3, 32'hFFFF_FF7F));
		// no register: absolute disp32 through SIB
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd6, 1'b0, 4'd8, 4'd9,
			2'd0, 2'd1, 32'h1234_5678));
		// two registers: rbp base swapped into the index, or kept with disp8
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd7, 1'b0, 4'd1, 4'd5,
			2'd2, 2'd0, 32'd0));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd8, 1'b0, 4'd13, 4'd5,
			2'd2, 2'd0, 32'd0));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd11, 1'b1, 4'd2, 4'd13,
			2'd2, 2'd2, 32'd0));
		// rsp first register with a second one: swapped to base
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd12, 1'b0, 4'd4, 4'd9,
			2'd2, 2'd0, 32'd1));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd13, 1'b0, 4'd4, 4'd5,
			2'd2, 2'd0, 32'd0));
		// illegal rsp uses, encoded without a check
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd14, 1'b0, 4'd4, 4'd4,
			2'd2, 2'd0, 32'd300));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd0, 1'b1, 4'd4, 4'd0,
			2'd1, 2'd2, 32'd0));
		// count three acts as two
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd15, 1'b0, 4'd10, 4'd11,
			2'd3, 2'd1, 32'hFFFF_FFFF));
		offer_operand(make_operand(ACT_RM, KIND_MEM, 4'd9, 1'b1, 4'd15, 4'd14,
			2'd2, 2'd3, 32'h8000_0000));

		// random words with gaps on both sides
		repeat (130) offer_operand(random_operand());

		// long output hold while words keep coming
		hold_output = 1'b1;
		repeat (30) offer_operand(random_operand());

		// gap-free stretch
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (45) offer_operand(random_operand());

		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		repeat (33) offer_operand(random_operand());

		s_tvalid <= 1'b0;
		// let the checker queue the bytes of the last word first
		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && bytes_due == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
